FILE: rtl/core/aaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertising announcement filter: shared definitions
// Field widths, operation and status codes, register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aaf_pkg;

   // default device table depth
   localparam int TABLE_DEPTH_DEF = 16;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int UUID_W   = 16;
   localparam int BID_W    = 24;
   localparam int ADDR_W   = 48;
   localparam int ATYPE_W  = 2;
   localparam int SET_W    = 4;
   localparam int STATUS_W = 2;
   localparam int EIDX_W   = 4;
   localparam int ECNT_W   = 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVICE_DATA_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_UUID       = 2'd1;

   // register reset values
   localparam logic [BYTE_W-1:0] SERVICE_DATA_TYPE_RST = 8'd22;
   localparam logic [UUID_W-1:0] TARGET_UUID_RST       = 16'd6226;

   // operation codes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_KNOWN = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic accept;        // input transfer this cycle
      logic search_start;  // last byte taken: latch sender, rewind walk
      logic rd_en;         // read the table entry at the walk index
      logic idx_inc;       // step the walk index
      logic set_hit;       // sender found at the walk index
      logic finish;        // load result register, commit a new entry
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_at_end;    // walk index reached the device count
      logic hit;           // registered entry matches the sender
   } dp_sts_type;

endpackage

FILE: rtl/core/aaf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertising announcement filter: controller
// Takes input transfers, sequences the table walk after the last byte of a
// report and hands the result to the output register.
// ----------------------------------------------------------------------------
module aaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output aaf_pkg::ctrl_cmd_type cmd,
   input  aaf_pkg::dp_sts_type   sts
);
   import aaf_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // commands
   always_comb begin
      cmd              = '0;
      cmd.accept       = accept;
      cmd.search_start = accept && (req_operation == OP_BYTE) && req_last_byte;
      cmd.rd_en        = (state_ff == S_READ) && !sts.idx_at_end;
      cmd.idx_inc      = (state_ff == S_CMP) && !sts.hit;
      cmd.set_hit      = (state_ff == S_CMP) && sts.hit;
      cmd.finish       = (state_ff == S_FINISH) && out_free;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.search_start) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = sts.idx_at_end ? S_FINISH : S_CMP;
         end
         S_CMP: begin
            state_in = sts.hit ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/aaf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertising announcement filter: datapath
// Length-type structure parser, configuration registers, device table
// memory with its walk index, and the result register.
// ----------------------------------------------------------------------------
module aaf_datapath #(
   parameter int TABLE_DEPTH = aaf_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aaf_pkg::ctrl_cmd_type             cmd,
   output aaf_pkg::dp_sts_type               sts,
   input  logic                              csr_wr_en,
   input  logic [aaf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aaf_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                              req_operation,
   input  logic [aaf_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic [aaf_pkg::BYTE_W-1:0]        req_report_length,
   input  logic                              req_first_byte,
   input  logic [aaf_pkg::ADDR_W-1:0]        req_device_address,
   input  logic [aaf_pkg::ATYPE_W-1:0]       req_address_type,
   input  logic [aaf_pkg::SET_W-1:0]         req_advertising_set,
   output logic [aaf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [aaf_pkg::BID_W-1:0]         rsp_bcast_id,
   output logic [aaf_pkg::EIDX_W-1:0]        rsp_entry_index,
   output logic [aaf_pkg::ECNT_W-1:0]        rsp_entry_count
);
   import aaf_pkg::*;

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = SET_W + BID_W + ATYPE_W + ADDR_W;
   localparam int POS_W   = BYTE_W + 2;

   typedef enum logic [2:0] {
      PH_LEN,
      PH_TYPE,
      PH_UUID_LO,
      PH_UUID_HI,
      PH_ID0,
      PH_ID1,
      PH_ID2,
      PH_SKIP
   } phase_type;

   // configuration
   logic [BYTE_W-1:0] sdt_ff;
   logic [UUID_W-1:0] target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sdt_ff    <= SERVICE_DATA_TYPE_RST;
         target_ff <= TARGET_UUID_RST;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SERVICE_DATA_TYPE) begin
            sdt_ff <= csr_wr_data[BYTE_W-1:0];
         end
         if (csr_index == CSR_TARGET_UUID) begin
            target_ff <= csr_wr_data[UUID_W-1:0];
         end
      end
   end

   // parse state
   logic [BYTE_W-1:0] pos_ff, pos_in, cur_pos;
   logic [BYTE_W-1:0] rem_ff, rem_in, cur_rem, rem_dec;
   phase_type         phase_ff, phase_in, cur_phase;
   logic [UUID_W-1:0] uuid_ff, uuid_in, cur_uuid;
   logic [BID_W-1:0]  cid_ff, cid_in, cur_cid;
   logic              found_ff, found_in, cur_found;
   logic              stop_ff, stop_in, cur_stop;
   logic [POS_W-1:0]  struct_end;
   logic              take_byte;

   assign take_byte = cmd.accept && (req_operation == OP_BYTE);

   // a first byte restarts from the reset state
   always_comb begin
      if (req_first_byte) begin
         cur_pos   = '0;
         cur_rem   = '0;
         cur_phase = PH_LEN;
         cur_uuid  = '0;
         cur_cid   = '0;
         cur_found = 1'b0;
         cur_stop  = 1'b0;
      end else begin
         cur_pos   = pos_ff;
         cur_rem   = rem_ff;
         cur_phase = phase_ff;
         cur_uuid  = uuid_ff;
         cur_cid   = cid_ff;
         cur_found = found_ff;
         cur_stop  = stop_ff;
      end
   end

   assign rem_dec    = cur_rem - 8'd1;
   assign struct_end = {2'b00, cur_pos} + POS_W'(1) + {2'b00, req_data_byte};

   // structure walker
   always_comb begin
      rem_in   = cur_rem;
      phase_in = cur_phase;
      uuid_in  = cur_uuid;
      cid_in   = cur_cid;
      found_in = cur_found;
      stop_in  = cur_stop;
      pos_in   = (cur_pos == '1) ? cur_pos : cur_pos + 8'd1;
      if (!cur_stop && (cur_pos < req_report_length)) begin
         unique case (cur_phase)
            PH_LEN: begin
               rem_in = req_data_byte;
               if (req_data_byte == '0) begin
                  stop_in = 1'b1;
               end else if ((req_data_byte >= 8'd2) &&
                            (struct_end <= {2'b00, req_report_length})) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_TYPE: begin
               rem_in = rem_dec;
               if ((req_data_byte == sdt_ff) && (rem_dec >= 8'd5)) begin
                  phase_in = PH_UUID_LO;
               end else begin
                  phase_in = (rem_dec == '0) ? PH_LEN : PH_SKIP;
               end
            end
            PH_UUID_LO: begin
               rem_in   = rem_dec;
               uuid_in  = {8'h00, req_data_byte};
               phase_in = PH_UUID_HI;
            end
            PH_UUID_HI: begin
               rem_in  = rem_dec;
               uuid_in = {req_data_byte, cur_uuid[7:0]};
               if ({req_data_byte, cur_uuid[7:0]} == target_ff) begin
                  phase_in = PH_ID0;
               end else begin
                  phase_in = (rem_dec == '0) ? PH_LEN : PH_SKIP;
               end
            end
            PH_ID0: begin
               rem_in   = rem_dec;
               cid_in   = {16'h0000, req_data_byte};
               phase_in = PH_ID1;
            end
            PH_ID1: begin
               rem_in   = rem_dec;
               cid_in   = cur_cid | {8'h00, req_data_byte, 8'h00};
               phase_in = PH_ID2;
            end
            PH_ID2: begin
               rem_in   = rem_dec;
               cid_in   = cur_cid | {req_data_byte, 16'h0000};
               found_in = 1'b1;
               stop_in  = 1'b1;
            end
            PH_SKIP: begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_LEN;
               end
            end
            default: begin
               phase_in = PH_LEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rem_ff   <= '0;
         phase_ff <= PH_LEN;
         uuid_ff  <= '0;
         cid_ff   <= '0;
         found_ff <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (take_byte) begin
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         phase_ff <= phase_in;
         uuid_ff  <= uuid_in;
         cid_ff   <= cid_in;
         found_ff <= found_in;
         stop_ff  <= stop_in;
      end
   end

   // sender of the report under lookup
   logic [ADDR_W-1:0]  addr_ff;
   logic [ATYPE_W-1:0] atype_ff;
   logic [SET_W-1:0]   set_ff;

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         addr_ff  <= req_device_address;
         atype_ff <= req_address_type;
         set_ff   <= req_advertising_set;
      end
   end

   // device count, walk index and hit flag
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             known_ff;
   logic             room;
   logic             add_entry;

   assign room      = (count_ff < CNT_W'(TABLE_DEPTH));
   assign add_entry = cmd.finish && !known_ff && found_ff && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         known_ff <= 1'b0;
      end else begin
         if (cmd.accept && (req_operation == OP_CLEAR)) begin
            count_ff <= '0;
         end else if (add_entry) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.search_start) begin
            idx_ff   <= '0;
            known_ff <= 1'b0;
         end else begin
            if (cmd.idx_inc) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
            if (cmd.set_hit) begin
               known_ff <= 1'b1;
            end
         end
      end
   end

   // device table: one write, one registered read
   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ATYPE_W-1:0] rd_atype;
   logic [BID_W-1:0]   rd_bid;

   always_ff @(posedge clock) begin
      if (add_entry) begin
         table_mem[count_ff[IDX_W-1:0]] <= {set_ff, cid_ff, atype_ff, addr_ff};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign rd_addr  = rd_data_ff[ADDR_W-1:0];
   assign rd_atype = rd_data_ff[ADDR_W +: ATYPE_W];
   assign rd_bid   = rd_data_ff[ADDR_W+ATYPE_W +: BID_W];

   assign sts.idx_at_end = (idx_ff == count_ff);
   assign sts.hit        = (rd_addr == addr_ff) && (rd_atype == atype_ff);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (known_ff) begin
            rsp_status      <= ST_KNOWN;
            rsp_bcast_id    <= rd_bid;
            rsp_entry_index <= EIDX_W'(idx_ff);
            rsp_entry_count <= ECNT_W'(count_ff);
         end else if (!found_ff) begin
            rsp_status      <= ST_NONE;
            rsp_bcast_id    <= '0;
            rsp_entry_index <= '0;
            rsp_entry_count <= ECNT_W'(count_ff);
         end else if (room) begin
            rsp_status      <= ST_ADDED;
            rsp_bcast_id    <= cid_ff;
            rsp_entry_index <= EIDX_W'(count_ff);
            rsp_entry_count <= ECNT_W'(count_ff + CNT_W'(1));
         end else begin
            rsp_status      <= ST_FULL;
            rsp_bcast_id    <= cid_ff;
            rsp_entry_index <= '0;
            rsp_entry_count <= ECNT_W'(count_ff);
         end
      end
   end

endmodule

FILE: rtl/core/adv_announcement_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertising announcement filter
// Parses advertising report bytes for a broadcast announcement and keeps a
// bounded table of announcing devices.
//
// Usage: one report byte (or a table clear) is a transfer on the req_
// channel; sender address, type and set travel with every byte. A byte
// without last_byte and a clear give no result and start no table walk.
// A last byte starts a walk of the device table from its first entry: S_READ
// reads an entry through the registered read port of the table memory and
// S_CMP compares it with the sender. The walk ends at the device count, or
// early at the entry that holds the sender, and S_FINISH loads the result.
// req_ready is low from the transfer until rsp_valid rises.
// The result sits in an output register: further non-last bytes and clears
// are taken while it waits. When the receiver stalls, a finished lookup holds
// until the output register is free.
// Reset clears the parse state, the device count and the registers to their
// defaults; table contents need no clearing. csr_ writes take effect at once.
// The user makes csr_ writes only while the block is idle; it is unenforced.
// ----------------------------------------------------------------------------
module adv_announcement_filter #(
   parameter int TABLE_DEPTH = aaf_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [aaf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aaf_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [aaf_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic [aaf_pkg::BYTE_W-1:0]        req_report_length,
   input  logic                              req_first_byte,
   input  logic                              req_last_byte,
   input  logic [aaf_pkg::ADDR_W-1:0]        req_device_address,
   input  logic [aaf_pkg::ATYPE_W-1:0]       req_address_type,
   input  logic [aaf_pkg::SET_W-1:0]         req_advertising_set,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [aaf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [aaf_pkg::BID_W-1:0]         rsp_bcast_id,
   output logic [aaf_pkg::EIDX_W-1:0]        rsp_entry_index,
   output logic [aaf_pkg::ECNT_W-1:0]        rsp_entry_count
);
   import aaf_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   aaf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   aaf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_operation       (req_operation),
      .req_data_byte       (req_data_byte),
      .req_report_length   (req_report_length),
      .req_first_byte      (req_first_byte),
      .req_device_address  (req_device_address),
      .req_address_type    (req_address_type),
      .req_advertising_set (req_advertising_set),
      .rsp_status          (rsp_status),
      .rsp_bcast_id        (rsp_bcast_id),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_count     (rsp_entry_count)
   );

   // no announcement carries no ID and no slot
   a_none_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NONE)) |->
         ((rsp_bcast_id == '0) && (rsp_entry_index == '0)))
      else $error("no-announcement result carries an ID or slot");

   // a new entry lands in the slot just below the new count
   a_added_slot : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ADDED) && (TABLE_DEPTH <= 16)) |->
         (ECNT_W'(rsp_entry_index) + ECNT_W'(1) == rsp_entry_count))
      else $error("added slot does not match device count");

   // table full only when the count sits at the depth
   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |->
         ((rsp_entry_count == ECNT_W'(TABLE_DEPTH)) && (rsp_entry_index == '0)))
      else $error("table full reported below depth");

   // a fresh result comes only out of a table walk
   a_result_after_walk : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without a table walk");

endmodule
